[hw/rtl/prsd_pkg.sv]
// ----------------------------------------------------------------------------
// prsd_pkg
// Shared types, constants and the word decode for the record sync decoder.
// ----------------------------------------------------------------------------
package prsd_pkg;

    localparam int RECORD_BYTES = 14;
    localparam int CELLS        = RECORD_BYTES - 1;
    localparam int CNT_W        = $clog2(RECORD_BYTES);
    localparam int WORDS_OUT    = 7;

    localparam logic [7:0] MISS_LIMIT_RESET = 8'd10;
    localparam logic [7:0] MISS_MAX         = 8'hFF;

    typedef enum logic {
        KIND_REPORT = 1'b0,
        KIND_RESYNC = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                            kind;
        logic [WORDS_OUT-1:0][15:0]       words;
    } t_result;

    // The low byte loses its sync bit; the pair forms {hi[6:0], lo[6:0], 00}.
    function automatic logic [15:0] decode_word(input logic [7:0] lo, input logic [7:0] hi);
        decode_word = {hi[6:0], lo[6:0], 2'b00};
    endfunction

endpackage

[hw/rtl/prsd_cell.sv]
// ----------------------------------------------------------------------------
// prsd_cell
// One byte cell of the record shift chain.
// ----------------------------------------------------------------------------
module prsd_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

[hw/rtl/phased_record_sync_decoder.sv]
// ----------------------------------------------------------------------------
// phased_record_sync_decoder
// Hunts for record sync in a serial byte stream and decodes complete records.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle. Received bytes run through a chain
// of byte cells; on the last byte of a record the seven words are decoded
// from the chain and the incoming byte in the same cycle, and the result
// goes to the output register, or to the skid register behind it while a
// stalled result waits there. The skid register lets the input keep taking
// bytes while a result waits; the input stalls only when both hold a request.
module phased_record_sync_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z
);

    import prsd_pkg::*;

    logic [7:0]       r_miss_limit;
    logic             r_in_record;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_miss;
    logic             r_out_v;
    logic             r_skd_v;
    t_result          r_out;
    t_result          r_skd;

    logic             n_in_record;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       n_miss;
    logic [7:0]       w_miss_inc;
    logic             w_accept;
    logic             w_res_v;
    t_result          w_res;
    logic [7:0]       w_chain [CELLS];
    logic [7:0]       w_rec [RECORD_BYTES];
    logic [WORDS_OUT-1:0][15:0] w_words;

    assign w_accept = i_valid & ~r_skd_v;
    assign o_stall  = r_skd_v;

    genvar g;
    generate
        for (g = 0; g < CELLS; g++) begin : g_cell
            prsd_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_accept),
                .i_byte ((g == 0) ? i_rx_byte : w_chain[(g == 0) ? 0 : g-1]),
                .o_byte (w_chain[g])
            );
        end
        for (g = 0; g < RECORD_BYTES; g++) begin : g_rec
            if (g == RECORD_BYTES - 1) begin : g_last
                assign w_rec[g] = i_rx_byte;
            end else begin : g_held
                assign w_rec[g] = w_chain[RECORD_BYTES - 2 - g];
            end
        end
        for (g = 0; g < WORDS_OUT; g++) begin : g_word
            if (2 * g + 1 < RECORD_BYTES) begin : g_used
                assign w_words[g] = decode_word(w_rec[2*g], w_rec[2*g+1]);
            end else begin : g_none
                assign w_words[g] = 16'd0;
            end
        end
    endgenerate

    assign w_miss_inc = (r_miss == MISS_MAX) ? MISS_MAX : r_miss + 8'd1;

    always_comb begin
        n_in_record = r_in_record;
        n_count     = r_count;
        n_miss      = r_miss;
        w_res_v     = 1'b0;
        w_res.kind  = KIND_REPORT;
        w_res.words = w_words;
        if (w_accept) begin
            if (!r_in_record) begin
                if (!i_rx_byte[7]) begin
                    n_miss = w_miss_inc;
                    if (w_miss_inc > r_miss_limit) begin
                        w_res_v     = 1'b1;
                        w_res.kind  = KIND_RESYNC;
                        w_res.words = '0;
                    end
                end else begin
                    n_miss      = 8'd0;
                    n_count     = CNT_W'(1);
                    n_in_record = 1'b1;
                end
            end else if (r_count == CNT_W'(RECORD_BYTES - 1)) begin
                w_res_v     = 1'b1;
                n_in_record = 1'b0;
                n_count     = '0;
            end else begin
                n_count = CNT_W'(r_count + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_limit <= MISS_LIMIT_RESET;
            r_in_record  <= 1'b0;
            r_count      <= '0;
            r_miss       <= 8'd0;
            r_out_v      <= 1'b0;
            r_skd_v      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_miss_limit <= i_cfg_wr_data;
            end
            r_in_record <= n_in_record;
            r_count     <= n_count;
            r_miss      <= n_miss;
            if (!r_out_v || !i_stall) begin
                if (r_skd_v) begin
                    r_out_v <= 1'b1;
                    r_skd_v <= 1'b0;
                end else begin
                    r_out_v <= w_res_v;
                end
            end else if (w_res_v) begin
                r_skd_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skd_v ? r_skd : w_res;
        end else if (w_res_v) begin
            r_skd <= w_res;
        end
    end

    assign o_valid  = r_out_v;
    assign o_kind   = r_out.kind;
    assign o_pos_x  = $signed(r_out.words[0]);
    assign o_pos_y  = $signed(r_out.words[1]);
    assign o_pos_z  = $signed(r_out.words[2]);
    assign o_quat_w = $signed(r_out.words[3]);
    assign o_quat_x = $signed(r_out.words[4]);
    assign o_quat_y = $signed(r_out.words[5]);
    assign o_quat_z = $signed(r_out.words[6]);

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the record sync decoder. A short table of bytes with
// hand-typed results comes first, then about two thousand random bytes shaped
// as records, noise bursts and stray bytes, all under several miss limits.
// The rest are checked field by field against an in-bench decoder model.
// ----------------------------------------------------------------------------
module tb;
    import prsd_pkg::*;

    localparam int ITEMS       = 1900;
    localparam int HOLD_CYCLES = 80;
    localparam int DIR_N       = 22;

    typedef enum logic {
        ROW_BYTE  = 1'b0,
        ROW_LIMIT = 1'b1
    } t_row_op;

    typedef struct packed {
        t_row_op     op;
        logic [7:0]  val;
        logic        pin;
        t_kind       pin_kind;
        logic [15:0] pin_word;
    } t_dir_row;

    // A record of all ones tests bit 7 inside a record; then the limit
    // extremes are tried on noise bytes.
    localparam t_dir_row DIR_ROWS [0:DIR_N-1] = '{
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'hFF, 1'b1, KIND_REPORT, 16'hFFFC},
        '{ROW_LIMIT, 8'h00, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'h00, 1'b1, KIND_RESYNC, 16'h0000},
        '{ROW_BYTE,  8'h7F, 1'b1, KIND_RESYNC, 16'h0000},
        '{ROW_LIMIT, 8'hFF, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'h55, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'h2A, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_BYTE,  8'h80, 1'b0, KIND_REPORT, 16'h0000},
        '{ROW_LIMIT, 8'h0A, 1'b0, KIND_REPORT, 16'h0000}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'h00;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_kind;
    logic signed [15:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [15:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;

    // Decoder model state.
    logic       in_frame = 1'b0;
    int         frame_fill = 0;
    logic [7:0] frame_buf [0:31];
    logic [7:0] miss_tally = 8'h00;
    logic [7:0] miss_limit = MISS_LIMIT_RESET;

    t_result pending_reports [$];
    string   word_name [0:WORDS_OUT-1] = '{"pos_x", "pos_y", "pos_z",
                                           "quat_w", "quat_x", "quat_y", "quat_z"};

    int  error_count = 0;
    int  report_count = 0;
    int  resync_count = 0;
    int  byte_total = 0;
    int  input_stall_cycles = 0;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    bit  hold_req = 1'b0;
    int  rx_run = 0;
    int  rx_pick;

    phased_record_sync_decoder u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_pos_z      (o_pos_z),
        .o_quat_w     (o_quat_w),
        .o_quat_x     (o_quat_x),
        .o_quat_y     (o_quat_y),
        .o_quat_z     (o_quat_z)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit track_byte(input logic [7:0] b, output t_result r);
        int          idx;
        logic [31:0] lo;
        logic [31:0] hi;
        r = '0;
        r.kind = KIND_REPORT;
        if (!in_frame) begin
            if (!b[7]) begin
                if (miss_tally != MISS_MAX)
                    miss_tally = miss_tally + 8'd1;
                if (miss_tally > miss_limit) begin
                    r.kind = KIND_RESYNC;
                    return 1'b1;
                end
                return 1'b0;
            end
            miss_tally = 8'h00;
            frame_buf[0] = b;
            frame_fill = 1;
            in_frame = 1'b1;
        end else begin
            if (frame_fill < 32)
                frame_buf[frame_fill] = b;
            frame_fill++;
        end
        if (frame_fill < RECORD_BYTES)
            return 1'b0;
        for (int j = 0; j < WORDS_OUT; j++) begin
            idx = 2 * j;
            if (idx + 1 < RECORD_BYTES) begin
                lo = {25'd0, frame_buf[idx][6:0]} << 1;
                hi = {24'd0, frame_buf[idx + 1]} << 8;
                r.words[j] = 16'((lo + hi) << 1);
            end
        end
        in_frame = 1'b0;
        frame_fill = 0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit pin, input t_result pin_r);
        int      gap;
        bit      got;
        t_result r;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) begin
            input_stall_cycles++;
            @(posedge i_clk);
        end
        got = track_byte(b, r);
        if (pin)
            pending_reports.push_back(pin_r);
        else if (got)
            pending_reports.push_back(r);
        byte_total++;
    endtask

    task automatic set_limit(input logic [7:0] v);
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        miss_limit = v;
    endtask

    task automatic send_record();
        push_byte({1'b1, 7'($urandom)}, 1'b0, '0);
        repeat (RECORD_BYTES - 1) push_byte(rand_byte(), 1'b0, '0);
    endtask

    task automatic send_noise(input int n);
        repeat (n) push_byte({1'b0, 7'($urandom)}, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_run = 0;
        end else if (rx_run > 0) begin
            rx_run--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            i_stall <= 1'b1;
            rx_run = HOLD_CYCLES;
        end else begin
            rx_pick = $urandom_range(0, 19);
            if (rx_pick < 8) begin
                i_stall <= 1'b0;
                rx_run = $urandom_range(0, 30);
            end else if (rx_pick < 18) begin
                i_stall <= 1'b1;
                rx_run = $urandom_range(0, 2);
            end else begin
                i_stall <= 1'b1;
                rx_run = $urandom_range(8, 40);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result                     exp_r;
        logic [WORDS_OUT-1:0][15:0]  got_w;
        if (i_rst_n && o_valid && !i_stall) begin
            got_w = {o_quat_z, o_quat_y, o_quat_x, o_quat_w, o_pos_z, o_pos_y, o_pos_x};
            if (o_kind == KIND_RESYNC)
                resync_count++;
            else
                report_count++;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, kind %0d", $time, o_kind);
                error_count++;
            end else begin
                exp_r = pending_reports.pop_front();
                if (o_kind !== exp_r.kind) begin
                    $display("%0t: kind expected %0d got %0d", $time, exp_r.kind, o_kind);
                    error_count++;
                end
                for (int j = 0; j < WORDS_OUT; j++) begin
                    if (got_w[j] !== exp_r.words[j]) begin
                        $display("%0t: %s expected %0d got %0d", $time, word_name[j],
                                 $signed(exp_r.words[j]), $signed(got_w[j]));
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        t_result pin_r;
        int      chunks;
        int      r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            if (DIR_ROWS[i].op == ROW_LIMIT) begin
                set_limit(DIR_ROWS[i].val);
            end else begin
                pin_r.kind = DIR_ROWS[i].pin_kind;
                pin_r.words = {WORDS_OUT{DIR_ROWS[i].pin_word}};
                push_byte(DIR_ROWS[i].val, DIR_ROWS[i].pin, pin_r);
            end
        end

        // Each noise byte outside a record raises a request; the receiver is made to hold off.
        set_limit(8'd0);
        gaps_on = 1'b0;
        hold_req = 1'b1;
        send_noise(60);
        send_record();
        send_noise(40);
        gaps_on = 1'b1;

        set_limit(8'd254);
        send_noise(300);
        send_record();
        set_limit(8'd255);
        send_noise(280);
        send_record();

        chunks = 0;
        while (byte_total < ITEMS) begin
            if (chunks == 0) begin
                if ($urandom_range(0, 3) == 0)
                    set_limit(8'($urandom));
                else
                    set_limit(8'($urandom_range(0, 20)));
                chunks = 14;
            end
            chunks--;
            r = $urandom_range(0, 9);
            if (r < 6)
                send_record();
            else if (r < 9)
                send_noise($urandom_range(1, 24));
            else
                repeat ($urandom_range(1, 8)) push_byte(rand_byte(), 1'b0, '0);
        end

        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Covered %0d bytes under several miss limits: %0d records and %0d resyncs",
                 byte_total, report_count, resync_count);
        $display("Input held off for %0d cycles while results backed up", input_stall_cycles);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[phased_record_sync_decoder.f]
hw/rtl/prsd_pkg.sv
hw/rtl/prsd_cell.sv
hw/rtl/phased_record_sync_decoder.sv
bench/tb.sv
